// ===== sv/stee_pkg.sv =====
package stee_pkg;

    localparam int DATA_W           = 32;
    localparam int CURRENT_W        = 16;
    localparam int VOLTAGE_W        = 16;
    localparam int CFG_INDEX_W      = 3;
    localparam int COUNTER_BITS_DEF = 32;

    // Multiply-accumulate unit: digit-serial over the multiplier.
    localparam int DIGIT_BITS = 4;
    localparam int ACC_W      = 66;
    localparam int DIGIT_CNT_W = 3;
    localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT_16 = DIGIT_CNT_W'(16 / DIGIT_BITS - 1);
    localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT_32 = DIGIT_CNT_W'(32 / DIGIT_BITS - 1);

    // Power divisor is floor(64 * dt / 1000).
    localparam int SCALE_SHIFT = 6;
    localparam logic [DATA_W-1:0] DIVR_DENOM = DATA_W'(1000);
    // The 60/40 average out of 100 reduces to (3 * avg + 2 * energy) / 5.
    localparam logic [DATA_W-1:0] AVG_DENOM = DATA_W'(5);
    localparam int AVG_SUM_W = DATA_W + 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_SUPPLY_VOLTAGE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_ENERGY      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CPU_CURRENT_Q6      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLEEP_CURRENT_Q6    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSMIT_CURRENT_Q6 = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LISTEN_CURRENT_Q6   = 3'd6;

    localparam logic [VOLTAGE_W-1:0] RST_SUPPLY_VOLTAGE      = 16'd3;
    localparam logic [DATA_W-1:0]    RST_INITIAL_ENERGY      = 32'd10000;
    localparam logic [DATA_W-1:0]    RST_TICKS_PER_SECOND    = 32'd32768;
    localparam logic [CURRENT_W-1:0] RST_CPU_CURRENT_Q6      = 16'd115;
    localparam logic [CURRENT_W-1:0] RST_SLEEP_CURRENT_Q6    = 16'd34;
    localparam logic [CURRENT_W-1:0] RST_TRANSMIT_CURRENT_Q6 = 16'd1113;
    localparam logic [CURRENT_W-1:0] RST_LISTEN_CURRENT_Q6   = 16'd1280;

    typedef struct packed {
        logic                   start;
        logic                   clear;
        logic [DIGIT_CNT_W-1:0] last_digit;
    } mac_ctl_t;

endpackage

// ===== sv/stee_if.sv =====
interface stee_sample_if;
    logic                        valid;
    logic                        ready;
    logic [stee_pkg::DATA_W-1:0] total_ticks;
    logic [stee_pkg::DATA_W-1:0] cpu_ticks;
    logic [stee_pkg::DATA_W-1:0] sleep_ticks;
    logic [stee_pkg::DATA_W-1:0] transmit_ticks;
    logic [stee_pkg::DATA_W-1:0] listen_ticks;

    modport source (output valid, total_ticks, cpu_ticks, sleep_ticks, transmit_ticks,
                    listen_ticks, input ready);
    modport sink (input valid, total_ticks, cpu_ticks, sleep_ticks, transmit_ticks,
                  listen_ticks, output ready);
endinterface

interface stee_result_if;
    logic                        valid;
    logic                        ready;
    logic [stee_pkg::DATA_W-1:0] average_energy;
    logic [stee_pkg::DATA_W-1:0] period_energy;
    logic [stee_pkg::DATA_W-1:0] average_power;
    logic                        divide_fault;

    modport source (output valid, average_energy, period_energy, average_power,
                    divide_fault, input ready);
    modport sink (input valid, average_energy, period_energy, average_power,
                  divide_fault, output ready);
endinterface

interface stee_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [stee_pkg::CFG_INDEX_W-1:0] index;
    logic [stee_pkg::DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/stee_mac.sv =====
module stee_mac
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  stee_pkg::mac_ctl_t             ctl,
    input  logic [stee_pkg::ACC_W-1:0]     mcand,
    input  logic [stee_pkg::DATA_W-1:0]    mplier,
    output logic                           busy,
    output logic                           done,
    output logic [stee_pkg::ACC_W-1:0]     acc
);

    logic [stee_pkg::ACC_W-1:0]       acc_reg;
    logic [stee_pkg::ACC_W-1:0]       mcand_reg;
    logic [stee_pkg::DATA_W-1:0]      mplier_reg;
    logic [stee_pkg::DIGIT_CNT_W-1:0] cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [stee_pkg::ACC_W-1:0]       partial;

    // One multiplier digit per cycle, least significant first.
    assign partial = mcand_reg *
                     stee_pkg::ACC_W'(mplier_reg[stee_pkg::DIGIT_BITS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.last_digit;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            if (ctl.clear)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_reg + partial;
            mcand_reg  <= mcand_reg << stee_pkg::DIGIT_BITS;
            mplier_reg <= mplier_reg >> stee_pkg::DIGIT_BITS;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// ===== sv/stee_div.sv =====
module stee_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [stee_pkg::DATA_W-1:0] rem_init,
    input  logic [stee_pkg::DATA_W-1:0] dividend,
    input  logic [stee_pkg::DATA_W-1:0] divisor,
    output logic                        busy,
    output logic                        done,
    output logic [stee_pkg::DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(stee_pkg::DATA_W);

    logic [stee_pkg::DATA_W-1:0] rem_reg;
    logic [stee_pkg::DATA_W-1:0] quo_reg;
    logic [stee_pkg::DATA_W-1:0] den_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [stee_pkg::DATA_W:0]   trial;
    logic [stee_pkg::DATA_W:0]   diff;
    logic                        fits;

    // Restoring division, one quotient bit per cycle. The remainder start
    // value is below the divisor, so the quotient fits in one word.
    assign trial = {rem_reg, quo_reg[stee_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(stee_pkg::DATA_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[stee_pkg::DATA_W-1:0] : trial[stee_pkg::DATA_W-1:0];
            quo_reg <= {quo_reg[stee_pkg::DATA_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/state_time_energy_ewma.sv =====
// Channel   Modport   Request carries
// sample    sink      total, cpu, sleep, transmit and listen tick counters
// result    source    average_energy, period_energy, average_power, divide_fault
// cfg       sink      register index and write data
//
// Each accepted sample is worked through by one 4-bit digit-serial multiply-accumulate
// unit and one bit-serial divider (up to four quotients per sample; the power division is
// skipped when the divisor is zero or the power saturates), used in turn.
// A finished result waits in the output register; the sequencer stalls only when a new
// result meets an unread one, and configuration waits while a sample is in progress.
// Reset clears the previous counters and loads the register defaults and the average.
module state_time_energy_ewma
#(
    parameter int COUNTER_BITS = stee_pkg::COUNTER_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    stee_sample_if.sink        sample,
    stee_result_if.source      result,
    stee_cfg_if.sink           cfg
);

    localparam int CW = (COUNTER_BITS >= stee_pkg::DATA_W) ? stee_pkg::DATA_W : COUNTER_BITS;
    localparam int DW = stee_pkg::DATA_W;

    typedef enum logic [4:0] {
        S_IDLE, S_TERM_GO, S_TERM_WAIT, S_VOLT_GO, S_VOLT_WAIT, S_DIVR_GO, S_DIVR_WAIT,
        S_SEC_GO, S_SEC_WAIT, S_PWR_CHECK, S_PWR_GO, S_PWR_WAIT, S_ENG_GO, S_ENG_WAIT,
        S_AVG_GO, S_AVG_WAIT, S_OUT
    } state_t;

    state_t                            state_reg;
    logic [stee_pkg::VOLTAGE_W-1:0]    voltage_reg;
    logic [DW-1:0]                     tps_reg;
    logic [stee_pkg::CURRENT_W-1:0]    current_reg [4];
    logic [DW-1:0]                     avg_reg;

    logic [CW-1:0]                     prev_total_reg;
    logic [CW-1:0]                     prev_term_reg [4];
    logic [DW-1:0]                     d_total_reg;
    logic [DW-1:0]                     d_term_reg [4];
    logic [1:0]                        term_reg;

    logic [DW-1:0]                     divr_reg;
    logic [DW-1:0]                     seconds_reg;
    logic [DW-1:0]                     power_reg;
    logic [DW-1:0]                     energy_reg;
    logic                              fault_reg;

    logic                              res_valid_reg;
    logic [DW-1:0]                     res_avg_reg;
    logic [DW-1:0]                     res_energy_reg;
    logic [DW-1:0]                     res_power_reg;
    logic                              res_fault_reg;

    stee_pkg::mac_ctl_t                mac_ctl;
    logic [stee_pkg::ACC_W-1:0]        mac_mcand;
    logic [DW-1:0]                     mac_mplier;
    logic                              mac_busy;
    logic                              mac_done;
    logic [stee_pkg::ACC_W-1:0]        mac_acc;

    logic                              div_start;
    logic [DW-1:0]                     div_rem_init;
    logic [DW-1:0]                     div_dividend;
    logic [DW-1:0]                     div_divisor;
    logic                              div_busy;
    logic                              div_done;
    logic [DW-1:0]                     div_quotient;

    logic [CW-1:0]                     in_term [4];
    logic [CW-1:0]                     in_total;
    logic [DW-1:0]                     tps_eff;
    logic [stee_pkg::AVG_SUM_W-1:0]    avg_sum;
    logic                              sample_accept;
    logic                              cfg_accept;

    assign in_total   = CW'(sample.total_ticks);
    assign in_term[0] = CW'(sample.cpu_ticks);
    assign in_term[1] = CW'(sample.sleep_ticks);
    assign in_term[2] = CW'(sample.transmit_ticks);
    assign in_term[3] = CW'(sample.listen_ticks);

    assign tps_eff = (tps_reg == '0) ? DW'(1) : tps_reg;
    assign avg_sum = (stee_pkg::AVG_SUM_W'(avg_reg) << 1) + stee_pkg::AVG_SUM_W'(avg_reg)
                   + (stee_pkg::AVG_SUM_W'(energy_reg) << 1);

    assign sample.ready  = (state_reg == S_IDLE);
    assign sample_accept = sample.valid && sample.ready;
    assign cfg.ready     = (state_reg == S_IDLE);
    assign cfg_accept    = cfg.valid && cfg.ready;

    always_comb
    begin
        mac_ctl.start      = 1'b0;
        mac_ctl.clear      = 1'b1;
        mac_ctl.last_digit = stee_pkg::LAST_DIGIT_16;
        mac_mcand          = stee_pkg::ACC_W'(d_term_reg[term_reg]);
        mac_mplier         = DW'(current_reg[term_reg]);
        case (state_reg)
            S_TERM_GO:
            begin
                mac_ctl.start = 1'b1;
                mac_ctl.clear = (term_reg == 2'd0);
            end
            S_VOLT_GO:
            begin
                mac_ctl.start = 1'b1;
                mac_mcand     = mac_acc;
                mac_mplier    = DW'(voltage_reg);
            end
            S_ENG_GO:
            begin
                mac_ctl.start      = 1'b1;
                mac_ctl.last_digit = stee_pkg::LAST_DIGIT_32;
                mac_mcand          = stee_pkg::ACC_W'(power_reg);
                mac_mplier         = seconds_reg;
            end
            default:
            begin
                mac_ctl.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_rem_init = '0;
        div_dividend = d_total_reg;
        div_divisor  = tps_eff;
        case (state_reg)
            S_DIVR_GO:
            begin
                // 64 * dt is split so the high bits start the remainder.
                div_start    = 1'b1;
                div_rem_init = DW'(d_total_reg[DW-1 -: stee_pkg::SCALE_SHIFT]);
                div_dividend = {d_total_reg[DW-stee_pkg::SCALE_SHIFT-1:0],
                                {stee_pkg::SCALE_SHIFT{1'b0}}};
                div_divisor  = stee_pkg::DIVR_DENOM;
            end
            S_SEC_GO:
            begin
                div_start = 1'b1;
            end
            S_PWR_GO:
            begin
                div_start    = 1'b1;
                div_rem_init = mac_acc[2*DW-1:DW];
                div_dividend = mac_acc[DW-1:0];
                div_divisor  = divr_reg;
            end
            S_AVG_GO:
            begin
                div_start    = 1'b1;
                div_rem_init = DW'(avg_sum[stee_pkg::AVG_SUM_W-1:DW]);
                div_dividend = avg_sum[DW-1:0];
                div_divisor  = stee_pkg::AVG_DENOM;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            voltage_reg    <= stee_pkg::RST_SUPPLY_VOLTAGE;
            tps_reg        <= stee_pkg::RST_TICKS_PER_SECOND;
            current_reg[0] <= stee_pkg::RST_CPU_CURRENT_Q6;
            current_reg[1] <= stee_pkg::RST_SLEEP_CURRENT_Q6;
            current_reg[2] <= stee_pkg::RST_TRANSMIT_CURRENT_Q6;
            current_reg[3] <= stee_pkg::RST_LISTEN_CURRENT_Q6;
            avg_reg        <= stee_pkg::RST_INITIAL_ENERGY;
            prev_total_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                prev_term_reg[i] <= '0;
            end
            term_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_accept)
            begin
                case (cfg.index)
                    stee_pkg::CFG_SUPPLY_VOLTAGE:
                        voltage_reg <= cfg.data[stee_pkg::VOLTAGE_W-1:0];
                    stee_pkg::CFG_INITIAL_ENERGY:
                        avg_reg <= cfg.data;
                    stee_pkg::CFG_TICKS_PER_SECOND:
                        tps_reg <= cfg.data;
                    stee_pkg::CFG_CPU_CURRENT_Q6:
                        current_reg[0] <= cfg.data[stee_pkg::CURRENT_W-1:0];
                    stee_pkg::CFG_SLEEP_CURRENT_Q6:
                        current_reg[1] <= cfg.data[stee_pkg::CURRENT_W-1:0];
                    stee_pkg::CFG_TRANSMIT_CURRENT_Q6:
                        current_reg[2] <= cfg.data[stee_pkg::CURRENT_W-1:0];
                    stee_pkg::CFG_LISTEN_CURRENT_Q6:
                        current_reg[3] <= cfg.data[stee_pkg::CURRENT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // In S_OUT an accepted result is replaced by the next one below.
            if (result.valid && result.ready && state_reg != S_OUT)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (sample_accept)
                    begin
                        d_total_reg    <= DW'(CW'(in_total - prev_total_reg));
                        prev_total_reg <= in_total;
                        for (int i = 0; i < 4; i++)
                        begin
                            d_term_reg[i]    <= DW'(CW'(in_term[i] - prev_term_reg[i]));
                            prev_term_reg[i] <= in_term[i];
                        end
                        term_reg  <= '0;
                        state_reg <= S_TERM_GO;
                    end
                end
                S_TERM_GO:
                    state_reg <= S_TERM_WAIT;
                S_TERM_WAIT:
                begin
                    if (mac_done)
                    begin
                        term_reg  <= term_reg + 1'b1;
                        state_reg <= (term_reg == 2'd3) ? S_VOLT_GO : S_TERM_GO;
                    end
                end
                S_VOLT_GO:
                    state_reg <= S_VOLT_WAIT;
                S_VOLT_WAIT:
                begin
                    if (mac_done)
                    begin
                        state_reg <= S_DIVR_GO;
                    end
                end
                S_DIVR_GO:
                    state_reg <= S_DIVR_WAIT;
                S_DIVR_WAIT:
                begin
                    if (div_done)
                    begin
                        divr_reg  <= div_quotient;
                        state_reg <= S_SEC_GO;
                    end
                end
                S_SEC_GO:
                    state_reg <= S_SEC_WAIT;
                S_SEC_WAIT:
                begin
                    if (div_done)
                    begin
                        seconds_reg <= div_quotient;
                        state_reg   <= S_PWR_CHECK;
                    end
                end
                S_PWR_CHECK:
                begin
                    // The quotient overflows one word exactly when the high
                    // part of the numerator reaches the divisor.
                    fault_reg <= (divr_reg == '0);
                    if (divr_reg == '0 ||
                        mac_acc[stee_pkg::ACC_W-1:DW] >= (stee_pkg::ACC_W-DW)'(divr_reg))
                    begin
                        power_reg <= '1;
                        state_reg <= S_ENG_GO;
                    end
                    else
                    begin
                        state_reg <= S_PWR_GO;
                    end
                end
                S_PWR_GO:
                    state_reg <= S_PWR_WAIT;
                S_PWR_WAIT:
                begin
                    if (div_done)
                    begin
                        power_reg <= div_quotient;
                        state_reg <= S_ENG_GO;
                    end
                end
                S_ENG_GO:
                    state_reg <= S_ENG_WAIT;
                S_ENG_WAIT:
                begin
                    if (mac_done)
                    begin
                        energy_reg <= (mac_acc[stee_pkg::ACC_W-1:DW] != '0) ? '1
                                                                            : mac_acc[DW-1:0];
                        state_reg  <= S_AVG_GO;
                    end
                end
                S_AVG_GO:
                    state_reg <= S_AVG_WAIT;
                S_AVG_WAIT:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= div_quotient;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!res_valid_reg || result.ready)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_avg_reg    <= avg_reg;
                        res_energy_reg <= energy_reg;
                        res_power_reg  <= power_reg;
                        res_fault_reg  <= fault_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.average_energy = res_avg_reg;
    assign result.period_energy  = res_energy_reg;
    assign result.average_power  = res_power_reg;
    assign result.divide_fault   = res_fault_reg;

    stee_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .mcand  (mac_mcand),
        .mplier (mac_mplier),
        .busy   (mac_busy),
        .done   (mac_done),
        .acc    (mac_acc)
    );

    stee_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // The two arithmetic units are used strictly in turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mac_busy && div_busy))
        else $error("multiplier and divider busy together");

    // A divider result only arrives while the sequencer waits for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVR_WAIT || state_reg == S_SEC_WAIT ||
                      state_reg == S_PWR_WAIT || state_reg == S_AVG_WAIT))
        else $error("divider finished outside a wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.divide_fault |-> result.average_power == '1)
        else $error("fault without saturated power");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.average_power == '0 |-> result.period_energy == '0)
        else $error("energy without power");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_accept && cfg.index == stee_pkg::CFG_INITIAL_ENERGY |=>
            avg_reg == $past(cfg.data))
        else $error("initial energy not loaded into the average");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES       = 6_000_000;
    localparam int HOLD_AFTER_RESULTS = 60;
    localparam int LONG_HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES      = 400;

    localparam int DIVISOR_SHIFT = 6;
    localparam int DIVISOR_DENOM = 1000;
    localparam int AVG_KEEP_PCT  = 60;
    localparam int AVG_NEW_PCT   = 40;
    localparam int AVG_SCALE_PCT = 100;

    localparam logic [stee_pkg::CFG_INDEX_W-1:0] CFG_NO_REGISTER = 3'd7;
    localparam logic [stee_pkg::DATA_W-1:0]      ALL_ONES        = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [stee_pkg::DATA_W-1:0] total_ticks;
        logic [stee_pkg::DATA_W-1:0] cpu_ticks;
        logic [stee_pkg::DATA_W-1:0] sleep_ticks;
        logic [stee_pkg::DATA_W-1:0] transmit_ticks;
        logic [stee_pkg::DATA_W-1:0] listen_ticks;
    } tick_sample_t;

    typedef struct packed {
        logic [stee_pkg::DATA_W-1:0] average_energy;
        logic [stee_pkg::DATA_W-1:0] period_energy;
        logic [stee_pkg::DATA_W-1:0] average_power;
        logic                        divide_fault;
    } energy_estimate_t;

    class energy_scoreboard;
        logic [stee_pkg::VOLTAGE_W-1:0] supply_voltage;
        logic [stee_pkg::DATA_W-1:0]    initial_energy;
        logic [stee_pkg::DATA_W-1:0]    ticks_per_second;
        logic [stee_pkg::CURRENT_W-1:0] cpu_current;
        logic [stee_pkg::CURRENT_W-1:0] sleep_current;
        logic [stee_pkg::CURRENT_W-1:0] transmit_current;
        logic [stee_pkg::CURRENT_W-1:0] listen_current;
        tick_sample_t                   last_counts;
        logic [stee_pkg::DATA_W-1:0]    energy_average;
        energy_estimate_t               expected_estimates[$];
        int                             failures;

        function new();
            supply_voltage   = stee_pkg::RST_SUPPLY_VOLTAGE;
            initial_energy   = stee_pkg::RST_INITIAL_ENERGY;
            ticks_per_second = stee_pkg::RST_TICKS_PER_SECOND;
            cpu_current      = stee_pkg::RST_CPU_CURRENT_Q6;
            sleep_current    = stee_pkg::RST_SLEEP_CURRENT_Q6;
            transmit_current = stee_pkg::RST_TRANSMIT_CURRENT_Q6;
            listen_current   = stee_pkg::RST_LISTEN_CURRENT_Q6;
            last_counts      = '0;
            energy_average   = stee_pkg::RST_INITIAL_ENERGY;
            failures         = 0;
        endfunction

        function void write_reg(logic [stee_pkg::CFG_INDEX_W-1:0] index,
                                logic [stee_pkg::DATA_W-1:0] data);
            case (index)
                stee_pkg::CFG_SUPPLY_VOLTAGE:
                    supply_voltage = data[stee_pkg::VOLTAGE_W-1:0];
                stee_pkg::CFG_INITIAL_ENERGY:
                begin
                    initial_energy = data;
                    energy_average = data;
                end
                stee_pkg::CFG_TICKS_PER_SECOND:
                    ticks_per_second = data;
                stee_pkg::CFG_CPU_CURRENT_Q6:
                    cpu_current = data[stee_pkg::CURRENT_W-1:0];
                stee_pkg::CFG_SLEEP_CURRENT_Q6:
                    sleep_current = data[stee_pkg::CURRENT_W-1:0];
                stee_pkg::CFG_TRANSMIT_CURRENT_Q6:
                    transmit_current = data[stee_pkg::CURRENT_W-1:0];
                stee_pkg::CFG_LISTEN_CURRENT_Q6:
                    listen_current = data[stee_pkg::CURRENT_W-1:0];
                default: ;
            endcase
        endfunction

        // Counters wrap, so the 32-bit difference is the elapsed count.
        function energy_estimate_t estimate_period(tick_sample_t s);
            logic [stee_pkg::DATA_W-1:0] d_total;
            logic [stee_pkg::DATA_W-1:0] d_cpu;
            logic [stee_pkg::DATA_W-1:0] d_sleep;
            logic [stee_pkg::DATA_W-1:0] d_transmit;
            logic [stee_pkg::DATA_W-1:0] d_listen;
            logic [63:0]                 current_sum;
            logic [95:0]                 numerator;
            logic [95:0]                 quotient;
            logic [63:0]                 divisor;
            logic [63:0]                 power;
            logic [63:0]                 tps;
            logic [63:0]                 seconds;
            logic [63:0]                 energy;
            energy_estimate_t            r;
            d_total    = s.total_ticks - last_counts.total_ticks;
            d_cpu      = s.cpu_ticks - last_counts.cpu_ticks;
            d_sleep    = s.sleep_ticks - last_counts.sleep_ticks;
            d_transmit = s.transmit_ticks - last_counts.transmit_ticks;
            d_listen   = s.listen_ticks - last_counts.listen_ticks;
            last_counts = s;

            current_sum = 64'(d_cpu) * 64'(cpu_current) + 64'(d_sleep) * 64'(sleep_current)
                        + 64'(d_transmit) * 64'(transmit_current)
                        + 64'(d_listen) * 64'(listen_current);
            numerator = 96'(current_sum) * 96'(supply_voltage);
            divisor = (64'(d_total) << DIVISOR_SHIFT) / 64'(DIVISOR_DENOM);
            if (divisor == 64'd0)
            begin
                power = 64'(ALL_ONES);
                r.divide_fault = 1'b1;
            end
            else
            begin
                quotient = numerator / 96'(divisor);
                power = (quotient > 96'(ALL_ONES)) ? 64'(ALL_ONES) : quotient[63:0];
                r.divide_fault = 1'b0;
            end

            tps = (ticks_per_second == '0) ? 64'd1 : 64'(ticks_per_second);
            seconds = 64'(d_total) / tps;
            energy = power * seconds;
            if (energy > 64'(ALL_ONES))
                energy = 64'(ALL_ONES);

            energy_average = stee_pkg::DATA_W'((64'(energy_average) * AVG_KEEP_PCT
                                                + energy * AVG_NEW_PCT) / AVG_SCALE_PCT);
            r.average_energy = energy_average;
            r.period_energy  = energy[stee_pkg::DATA_W-1:0];
            r.average_power  = power[stee_pkg::DATA_W-1:0];
            return r;
        endfunction

        function void note_sample(tick_sample_t s);
            expected_estimates.push_back(estimate_period(s));
        endfunction

        function string show(energy_estimate_t e);
            return $sformatf("avg=%0d energy=%0d power=%0d fault=%0b", e.average_energy,
                             e.period_energy, e.average_power, e.divide_fault);
        endfunction

        function void report_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_result(energy_estimate_t got);
            energy_estimate_t want;
            if (expected_estimates.size() == 0)
            begin
                report_failure({"result with no request pending: ", show(got)});
                return;
            end
            want = expected_estimates.pop_front();
            if (got !== want)
                report_failure({"expected ", show(want), " got ", show(got)});
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    bit   calm;

    energy_scoreboard sb;
    tick_sample_t     counts;

    stee_sample_if sample_ch();
    stee_result_if result_ch();
    stee_cfg_if    cfg_ch();

    state_time_energy_ewma dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly back-to-back, some short gaps, now and then a long one.
    function automatic int pick_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 4);
        if (roll < 98)
            return $urandom_range(5, 40);
        return $urandom_range(100, 400);
    endfunction

    function automatic logic [stee_pkg::DATA_W-1:0] state_delta(
        logic [stee_pkg::DATA_W-1:0] dt);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return '0;
        if (roll < 85)
            return $urandom_range(0, dt);
        return $urandom();
    endfunction

    // Mostly plausible residency counters; a few requests are pure noise.
    function automatic tick_sample_t next_sample();
        tick_sample_t                s;
        logic [stee_pkg::DATA_W-1:0] dt;
        logic [stee_pkg::DATA_W-1:0] tps;
        int unsigned                 roll;
        roll = $urandom_range(0, 99);
        tps = (sb.ticks_per_second == '0) ? stee_pkg::DATA_W'(1) : sb.ticks_per_second;
        if (roll < 8)
        begin
            s.total_ticks    = $urandom();
            s.cpu_ticks      = $urandom();
            s.sleep_ticks    = $urandom();
            s.transmit_ticks = $urandom();
            s.listen_ticks   = $urandom();
            return s;
        end
        if (roll < 18)
            dt = $urandom_range(0, 15);
        else if (roll < 25)
            dt = $urandom_range(16, 300);
        else if (roll < 50)
            dt = $urandom_range(1000, 1 << 20);
        else if (roll < 80)
            dt = tps * stee_pkg::DATA_W'($urandom_range(1, 6))
               + stee_pkg::DATA_W'($urandom_range(0, 999));
        else
            dt = $urandom();
        s.total_ticks    = counts.total_ticks + dt;
        s.cpu_ticks      = counts.cpu_ticks + state_delta(dt);
        s.sleep_ticks    = counts.sleep_ticks + state_delta(dt);
        s.transmit_ticks = counts.transmit_ticks + state_delta(dt);
        s.listen_ticks   = counts.listen_ticks + state_delta(dt);
        return s;
    endfunction

    task automatic send_sample(input tick_sample_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.total_ticks    <= s.total_ticks;
        sample_ch.cpu_ticks      <= s.cpu_ticks;
        sample_ch.sleep_ticks    <= s.sleep_ticks;
        sample_ch.transmit_ticks <= s.transmit_ticks;
        sample_ch.listen_ticks   <= s.listen_ticks;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sb.note_sample(s);
        counts = s;
    endtask

    task automatic send_step(input logic [stee_pkg::DATA_W-1:0] dt,
                             input logic [stee_pkg::DATA_W-1:0] dc,
                             input logic [stee_pkg::DATA_W-1:0] ds,
                             input logic [stee_pkg::DATA_W-1:0] dx,
                             input logic [stee_pkg::DATA_W-1:0] dl);
        tick_sample_t s;
        s.total_ticks    = counts.total_ticks + dt;
        s.cpu_ticks      = counts.cpu_ticks + dc;
        s.sleep_ticks    = counts.sleep_ticks + ds;
        s.transmit_ticks = counts.transmit_ticks + dx;
        s.listen_ticks   = counts.listen_ticks + dl;
        send_sample(s);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            send_sample(next_sample());
    endtask

    // Registers may only change once the block has handed back every result.
    task automatic finish_phase();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_estimates.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [stee_pkg::CFG_INDEX_W-1:0] index,
                             input logic [stee_pkg::DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_reg(index, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // The 16-bit registers get random upper bits, which must be dropped.
    task automatic configure(input logic [stee_pkg::VOLTAGE_W-1:0] volts,
                             input logic [stee_pkg::DATA_W-1:0] init,
                             input logic [stee_pkg::DATA_W-1:0] tps,
                             input logic [stee_pkg::CURRENT_W-1:0] cpu,
                             input logic [stee_pkg::CURRENT_W-1:0] slp,
                             input logic [stee_pkg::CURRENT_W-1:0] tx,
                             input logic [stee_pkg::CURRENT_W-1:0] lis);
        write_reg(stee_pkg::CFG_SUPPLY_VOLTAGE, {16'($urandom()), volts});
        write_reg(stee_pkg::CFG_INITIAL_ENERGY, init);
        write_reg(stee_pkg::CFG_TICKS_PER_SECOND, tps);
        write_reg(stee_pkg::CFG_CPU_CURRENT_Q6, {16'($urandom()), cpu});
        write_reg(stee_pkg::CFG_SLEEP_CURRENT_Q6, {16'($urandom()), slp});
        write_reg(stee_pkg::CFG_TRANSMIT_CURRENT_Q6, {16'($urandom()), tx});
        write_reg(stee_pkg::CFG_LISTEN_CURRENT_Q6, {16'($urandom()), lis});
    endtask

    task automatic configure_random(input bit zero_rate);
        logic [stee_pkg::DATA_W-1:0]    tps;
        logic [stee_pkg::VOLTAGE_W-1:0] volts;
        logic [stee_pkg::CURRENT_W-1:0] limit;
        int unsigned                    roll;
        roll = $urandom_range(0, 2);
        if (zero_rate)
            tps = '0;
        else if (roll == 0)
            tps = $urandom_range(1, 1000);
        else if (roll == 1)
            tps = stee_pkg::RST_TICKS_PER_SECOND;
        else
            tps = $urandom();
        // Modest settings keep power below saturation for much of the phase.
        if ($urandom_range(0, 1) == 0)
        begin
            volts = stee_pkg::VOLTAGE_W'($urandom_range(1, 10));
            limit = stee_pkg::CURRENT_W'(2000);
        end
        else
        begin
            volts = stee_pkg::VOLTAGE_W'($urandom());
            limit = 16'hFFFF;
        end
        configure(volts, $urandom(), tps,
                  stee_pkg::CURRENT_W'($urandom_range(0, limit)),
                  stee_pkg::CURRENT_W'($urandom_range(0, limit)),
                  stee_pkg::CURRENT_W'($urandom_range(0, limit)),
                  stee_pkg::CURRENT_W'($urandom_range(0, limit)));
    endtask

    initial
    begin
        int               stall_left;
        int               results_seen;
        energy_estimate_t got;
        stall_left   = 0;
        results_seen = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got.average_energy = result_ch.average_energy;
                got.period_energy  = result_ch.period_energy;
                got.average_power  = result_ch.average_power;
                got.divide_fault   = result_ch.divide_fault;
                sb.check_result(got);
                results_seen++;
                // One long hold-off so the block backs up and stalls its input.
                if (results_seen == HOLD_AFTER_RESULTS)
                    stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        sb     = new();
        calm   = 1'b0;
        counts = '0;
        rst_n                    <= 1'b0;
        sample_ch.valid          <= 1'b0;
        sample_ch.total_ticks    <= '0;
        sample_ch.cpu_ticks      <= '0;
        sample_ch.sleep_ticks    <= '0;
        sample_ch.transmit_ticks <= '0;
        sample_ch.listen_ticks   <= '0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.index             <= '0;
        cfg_ch.data              <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero period, the fault boundary at 15/16 ticks, a divisor
        // of one with a wrapped CPU counter, whole seconds, idle states, full wraps.
        send_step(0, 0, 0, 0, 0);
        send_step(15, 15, 0, 0, 0);
        send_step(16, 16, 0, 0, 0);
        send_step(16, ALL_ONES, 31, 31, 31);
        send_step(32768, 10000, 20000, 1000, 1768);
        send_step(5 * 32768 + 7, 0, 0, 0, 0);
        send_step(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_step(1, 1, 1, 1, 1);
        send_step(1000, 0, 1000, 0, 0);
        send_step(1000, 0, 0, 1000, 0);
        send_step(1000, 0, 0, 0, 1000);
        send_step(32'h8000_0000, 32'h4000_0000, 32'h2000_0000, 32'h1000_0000, 32'h0800_0000);
        run_random(250);
        finish_phase();

        // Every register at its maximum; the numerator overflows 64 bits here.
        configure(16'hFFFF, ALL_ONES, ALL_ONES, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_step(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_step(0, 0, 0, 0, 0);
        send_step(16, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        run_random(150);
        finish_phase();

        // Every register at its minimum, an unmapped index, and no idling at all.
        configure(16'd0, 32'd0, 32'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        write_reg(CFG_NO_REGISTER, $urandom());
        calm = 1'b1;
        run_random(150);
        finish_phase();
        calm = 1'b0;

        // A rate of zero ticks per second counts as one.
        configure_random(1'b1);
        run_random(150);
        finish_phase();

        for (int phase = 0; phase < 5; phase++)
        begin
            configure_random(1'b0);
            run_random(210);
            finish_phase();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.expected_estimates.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
